@@ rtl/kxhd_pkg.sv @@
// Package for the keyed xorshift hex decoder: sizes, hash functions, queue entry type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package kxhd_pkg;
	localparam int MaxGroups = 32;
	localparam int CntW      = $clog2(MaxGroups + 1);
	localparam int IdxW      = $clog2(MaxGroups);
	localparam logic [15:0] KeyOffset = 16'd7;
	localparam logic [7:0]  Newline   = 8'd10;
	localparam logic [15:0] PwReset   = 16'd7;

	function automatic logic [15:0] xs_hash(input logic [15:0] v);
		logic [15:0] x;
		x = v ^ (v << 5);
		x = x ^ (x << 13);
		x = x ^ (x << 1);
		return x;
	endfunction

	function automatic logic [15:0] xs_unhash(input logic [15:0] v);
		logic [15:0] x;
		x = v;
		x = x ^ (x << 1);
		x = x ^ (x << 2);
		x = x ^ (x << 4);
		x = x ^ (x << 8);
		x = x ^ (x << 13);
		x = x ^ (x << 5);
		x = x ^ (x << 10);
		return x;
	endfunction

	function automatic logic [15:0] digit_value(input logic [7:0] c);
		if (c >= 8'd48 && c <= 8'd57) return {8'd0, c - 8'd48};
		return {8'd0, c} - 16'd55;
	endfunction

	// Front to back queue entry: a finished group and/or a message end.
	typedef struct packed {
		logic        has_group;
		logic [15:0] group;
		logic        msg_end;
	} kxhd_evt_t;
endpackage
`default_nettype wire

@@ rtl/kxhd_if.sv @@
// Valid/ready channel interfaces for input characters and decoded bytes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface kxhd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] hex_char;
	logic       message_end;
	modport source (output valid, hex_char, message_end, input ready);
	modport sink (input valid, hex_char, message_end, output ready);
endinterface

interface kxhd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_of_message;
	logic       decode_error;
	modport source (output valid, out_byte, last_of_message, decode_error, input ready);
	modport sink (input valid, out_byte, last_of_message, decode_error, output ready);
endinterface
`default_nettype wire

@@ rtl/kxhd_ram.sv @@
// Generic single-write, single-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module kxhd_ram #(
	parameter int Width = 16,
	parameter int Depth = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

@@ rtl/kxhd_front.sv @@
// Front end: assembles hex digits into groups, pushes group/end events.
// Depends on kxhd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module kxhd_front import kxhd_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	kxhd_in_if.sink    in_ch,
	output logic       push,
	output kxhd_evt_t  push_evt,
	input  wire logic  full
);
	logic [15:0] shift_q;
	logic [1:0]  dcnt_q;
	logic [15:0] nshift;
	logic        fire;

	assign in_ch.ready = !full;
	assign fire = in_ch.valid && !full;
	assign nshift = (shift_q << 4) | digit_value(in_ch.hex_char);
	assign push_evt.has_group = (dcnt_q == 2'd3);
	assign push_evt.group = nshift;
	assign push_evt.msg_end = in_ch.message_end;
	assign push = fire && (push_evt.has_group || in_ch.message_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= '0;
			dcnt_q  <= '0;
		end else if (fire) begin
			if (in_ch.message_end || dcnt_q == 2'd3) begin
				shift_q <= '0;
				dcnt_q  <= '0;
			end else begin
				shift_q <= nshift;
				dcnt_q  <= dcnt_q + 2'd1;
			end
		end
	end
endmodule
`default_nettype wire

@@ rtl/kxhd_fifo.sv @@
// Short event queue between front and back ends.
// Depends on kxhd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module kxhd_fifo import kxhd_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  kxhd_evt_t push_evt,
	output logic      full,
	input  wire logic pop,
	output kxhd_evt_t pop_evt,
	output logic      empty
);
	kxhd_evt_t   ent_q [4];
	logic [2:0]  wp_q, rp_q;

	assign full    = (wp_q - rp_q) == 3'd4;
	assign empty   = wp_q == rp_q;
	assign pop_evt = ent_q[rp_q[1:0]];

	always_ff @(posedge clk) begin
		if (push) ent_q[wp_q[1:0]] <= push_evt;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 3'd1;
			if (pop)  rp_q <= rp_q + 3'd1;
		end
	end
endmodule
`default_nettype wire

@@ rtl/kxhd_back.sv @@
// Back end: key chain, group store, division and output walk.
// Depends on kxhd_pkg, kxhd_ram, kxhd_out_if.
`timescale 1ns / 1ps
`default_nettype none
module kxhd_back import kxhd_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  cfg_we,
	input  wire logic [15:0] cfg_wdata,
	input  wire logic  empty,
	input  kxhd_evt_t  evt,
	output logic       pop,
	output logic       busy,
	kxhd_out_if.source out_ch
);
	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_DIV  = 5'b00010,
		ST_RD   = 5'b00100,
		ST_OUT  = 5'b01000,
		ST_NL   = 5'b10000
	} st_t;

	st_t         st_q;
	logic [15:0] key_q;
	logic [CntW-1:0] cnt_q;
	logic [31:0] total_q;
	logic        ovf_q, err_q;
	logic [31:0] rem_q, quo_q;
	logic [5:0]  bit_q;
	logic [CntW-1:0] idx_q;
	logic [15:0] v, rdata;
	logic        we;
	logic [32:0] trial;
	logic [31:0] rsh;
	logic [CntW-1:0] divisor;

	assign v  = (xs_unhash(evt.group) ^ key_q) - KeyOffset;
	assign busy = (st_q != ST_IDLE);
	assign pop = !empty && st_q == ST_IDLE;
	assign we  = pop && evt.has_group && cnt_q < CntW'(MaxGroups);
	assign divisor = cnt_q - CntW'(1);
	assign rsh = {rem_q[30:0], quo_q[31]};
	assign trial = {1'b0, rsh} - {{(33 - CntW){1'b0}}, divisor};

	kxhd_ram #(.Width(16), .Depth(MaxGroups)) u_store (
		.clk, .we, .waddr(cnt_q[IdxW-1:0]), .wdata(v),
		.raddr(idx_q[IdxW-1:0]), .rdata
	);

	assign out_ch.valid = (st_q == ST_OUT) || (st_q == ST_NL);
	assign out_ch.out_byte = (st_q == ST_NL) ? Newline : (quo_q[7:0] - rdata[7:0]);
	assign out_ch.last_of_message = (st_q == ST_NL);
	assign out_ch.decode_error = err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			key_q   <= xs_hash(PwReset);
			cnt_q   <= '0;
			total_q <= '0;
			ovf_q   <= 1'b0;
			err_q   <= 1'b0;
			rem_q   <= '0;
			quo_q   <= '0;
			bit_q   <= '0;
			idx_q   <= '0;
		end else begin
			if (cfg_we) key_q <= xs_hash(cfg_wdata);
			case (st_q)
				ST_IDLE: begin
					if (pop) begin
						logic [CntW-1:0] nc;
						logic [31:0]     nt;
						logic            no;
						nc = cnt_q; nt = total_q; no = ovf_q;
						if (evt.has_group) begin
							key_q <= xs_hash(evt.group ^ key_q);
							if (cnt_q < CntW'(MaxGroups)) begin
								nc = cnt_q + CntW'(1);
								nt = total_q + {16'd0, v};
							end else no = 1'b1;
						end
						cnt_q <= nc; total_q <= nt; ovf_q <= no;
						if (evt.msg_end) begin
							err_q <= no || nc == CntW'(1);
							rem_q <= '0;
							quo_q <= (nc >= CntW'(2)) ? nt : 32'd0;
							bit_q <= '0;
							idx_q <= '0;
							st_q  <= (nc >= CntW'(2)) ? ST_DIV
								: (nc == CntW'(1)) ? ST_RD : ST_NL;
						end
					end
				end
				ST_DIV: begin
					// restoring division, one quotient bit per cycle
					if (!trial[32]) begin
						rem_q <= trial[31:0];
						quo_q <= {quo_q[30:0], 1'b1};
					end else begin
						rem_q <= rsh;
						quo_q <= {quo_q[30:0], 1'b0};
					end
					bit_q <= bit_q + 6'd1;
					if (bit_q == 6'd31) st_q <= ST_RD;
				end
				ST_RD: st_q <= ST_OUT;
				ST_OUT: begin
					if (out_ch.ready) begin
						idx_q <= idx_q + CntW'(1);
						st_q  <= (idx_q + CntW'(1) == cnt_q) ? ST_NL : ST_RD;
					end
				end
				ST_NL: begin
					if (out_ch.ready) begin
						st_q    <= ST_IDLE;
						cnt_q   <= '0;
						total_q <= '0;
						ovf_q   <= 1'b0;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ rtl/keyed_xorshift_hex_decoder_core.sv @@
// Top level of the keyed xorshift hex decoder.
// Depends on kxhd_pkg, kxhd_if, kxhd_front, kxhd_fifo, kxhd_back.
//
// Usage:
//  - in_ch carries one ASCII character per transfer plus message_end.
//  - out_ch carries decoded bytes, then a newline with last_of_message.
//  - cfg_we/cfg_wdata write password_sum; the key reloads to its hash.
// Rate: the front takes one character a cycle while the four-entry event
//  queue has room; the back drains one event a cycle while idle. At
//  message end with two or more groups the back runs a bit-serial
//  divider, then RAM read and transfer states per byte, then the newline.
// Reset: key = hash(7), all message state cleared; the group store holds
//  junk until written and is only read below the group count.
// Stall: a stalled out_ch holds the back; the queue then fills and the
//  front deasserts ready, so no character is lost.
`timescale 1ns / 1ps
`default_nettype none
module keyed_xorshift_hex_decoder_core import kxhd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata,
	kxhd_in_if.sink          in_ch,
	kxhd_out_if.source       out_ch
);
	logic      push, pop, full, empty, busy;
	kxhd_evt_t push_evt, pop_evt;

	kxhd_front u_front (.clk, .arst_n, .in_ch, .push, .push_evt, .full);
	kxhd_fifo u_fifo (.clk, .arst_n, .push, .push_evt, .full, .pop, .pop_evt, .empty);
	kxhd_back u_back (.clk, .arst_n, .cfg_we, .cfg_wdata, .empty, .evt(pop_evt),
		.pop, .busy, .out_ch);

	// never push into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full)) else $error("event queue overrun");
	// output only while the back is walking a message
	a_out_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> busy) else $error("output outside walk");
	// no pop while the back end is busy
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !busy) else $error("pop while busy");
endmodule
`default_nettype wire
